FILE: sv/escaped_frame_decoder_unit_macros.svh
// assertion helpers for the asserting top-level file
`ifndef ESCAPED_FRAME_DECODER_UNIT_MACROS_SVH
`define ESCAPED_FRAME_DECODER_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define EFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define EFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/efd_pkg.sv
`default_nettype none

package efd_pkg;

  // raw line codes
  localparam logic [7:0] ESC_BYTE     = 8'h55;
  localparam logic [7:0] CODE_START   = 8'h01;
  localparam logic [7:0] CODE_LITERAL = 8'h02;
  localparam logic [7:0] CODE_END     = 8'h03;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_RESTART = 3'd1;
  localparam logic [2:0] KIND_GOOD    = 3'd2;
  localparam logic [2:0] KIND_BAD     = 3'd3;
  localparam logic [2:0] KIND_LENERR  = 3'd4;

  // field widths
  localparam int unsigned COUNT_W = 13;
  localparam logic [COUNT_W-1:0] MAX_LENGTH_RESET = 13'd256;

  // decoded operation codes passed from front to back
  localparam logic [1:0] OP_STORE   = 2'd0;
  localparam logic [1:0] OP_RESTART = 2'd1;
  localparam logic [1:0] OP_END     = 2'd2;

  typedef struct packed {
    logic [1:0] code;
    logic [7:0] data;
  } efd_op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } efd_qstat_t;

endpackage

`default_nettype wire

FILE: sv/efd_front.sv
`default_nettype none

module efd_front (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire  [7:0]       rx_byte,
  output logic             push,
  output efd_pkg::efd_op_t push_op,
  input  efd_pkg::efd_qstat_t qstat
);
  import efd_pkg::*;

  logic escape_pending;
  logic escape_pending_next;
  logic accept;

  // take a beat whenever the queue has room
  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  // classify the raw byte against the escape state
  always_comb begin
    push                = 1'b0;
    push_op.code        = OP_STORE;
    push_op.data        = rx_byte;
    escape_pending_next = escape_pending;
    if (accept) begin
      if (!escape_pending) begin
        if (rx_byte == ESC_BYTE) begin
          escape_pending_next = 1'b1;
        end else begin
          push = 1'b1;
        end
      end else begin
        escape_pending_next = 1'b0;
        push                = 1'b1;
        case (rx_byte)
          CODE_START: begin
            push_op.code = OP_RESTART;
            push_op.data = 8'h00;
          end
          CODE_LITERAL: begin
            push_op.data = ESC_BYTE;
          end
          CODE_END: begin
            push_op.code = OP_END;
            push_op.data = 8'h00;
          end
          default: begin
            push_op.data = rx_byte;
          end
        endcase
      end
    end
  end

  // escape state
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/efd_queue.sv
`default_nettype none

module efd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 push,
  input  efd_pkg::efd_op_t    push_op,
  input  wire                 pop,
  output efd_pkg::efd_op_t    pop_op,
  output efd_pkg::efd_qstat_t qstat
);
  import efd_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  efd_op_t       slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign qstat.full  = (fill == FULL_COUNT);
  assign qstat.empty = (fill == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign pop_op      = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/efd_back.sv
`default_nettype none

module efd_back (
  input  wire                          clk,
  input  wire                          rst,
  input  efd_pkg::efd_qstat_t          qstat,
  input  efd_pkg::efd_op_t             pop_op,
  output logic                         pop,
  input  wire  [efd_pkg::COUNT_W-1:0]  max_length,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [2:0]                   kind,
  output logic [7:0]                   payload_byte,
  output logic [efd_pkg::COUNT_W-1:0]  frame_count
);
  import efd_pkg::*;

  logic               held_valid;
  logic [7:0]         held_byte;
  logic [COUNT_W-1:0] byte_count;
  logic [7:0]         running_sum;

  logic               held_valid_next;
  logic [7:0]         held_byte_next;
  logic [COUNT_W-1:0] byte_count_next;
  logic [7:0]         running_sum_next;

  logic               res_valid;
  logic [2:0]         res_kind;
  logic [7:0]         res_byte;
  logic [COUNT_W-1:0] res_count;
  logic               out_free;
  logic               sum_ok;

  assign out_free = !out_valid || out_ready;
  assign sum_ok   = ((running_sum - held_byte) == held_byte);

  // execute the head operation against the frame state
  always_comb begin
    held_valid_next  = held_valid;
    held_byte_next   = held_byte;
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    res_valid        = 1'b0;
    res_kind         = KIND_PAYLOAD;
    res_byte         = 8'h00;
    res_count        = '0;
    case (pop_op.code)
      OP_STORE: begin
        if (byte_count >= max_length) begin
          res_valid       = 1'b1;
          res_kind        = KIND_LENERR;
          held_valid_next = 1'b0;
          held_byte_next  = 8'h00;
          byte_count_next = '0;
          running_sum_next = 8'h00;
        end else begin
          res_valid        = held_valid;
          res_byte         = held_byte;
          held_valid_next  = 1'b1;
          held_byte_next   = pop_op.data;
          byte_count_next  = byte_count + 1'b1;
          running_sum_next = running_sum + pop_op.data;
        end
      end
      OP_RESTART: begin
        res_valid        = 1'b1;
        res_kind         = KIND_RESTART;
        held_valid_next  = 1'b0;
        held_byte_next   = 8'h00;
        byte_count_next  = '0;
        running_sum_next = 8'h00;
      end
      OP_END: begin
        res_valid = 1'b1;
        if (byte_count == '0 || !held_valid) begin
          res_kind = KIND_LENERR;
        end else begin
          res_kind  = sum_ok ? KIND_GOOD : KIND_BAD;
          res_count = byte_count;
        end
        held_valid_next  = 1'b0;
        held_byte_next   = 8'h00;
        byte_count_next  = '0;
        running_sum_next = 8'h00;
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  // retire the head when its result, if any, has a place to go
  assign pop = !qstat.empty && (out_free || !res_valid);

  // frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid  <= 1'b0;
      held_byte   <= 8'h00;
      byte_count  <= '0;
      running_sum <= 8'h00;
    end else if (pop) begin
      held_valid  <= held_valid_next;
      held_byte   <= held_byte_next;
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      kind         <= res_kind;
      payload_byte <= res_byte;
      frame_count  <= res_count;
    end
  end

endmodule

`default_nettype wire

FILE: sv/escaped_frame_decoder_unit.sv
// result path: each op is written into the op queue, then the back end registers its result beat;
//   ops already queued ahead of it are retired first
// throughput: one byte per cycle while out_ready keeps the output free, set by the back-end frame update
// in_ready drops only when the op queue is full; an out_ready stall backs up the queue
// reset (rst, synchronous): clears escape state, frame state, queue, output valid;
//   max_length returns to 256
`default_nettype none

`include "escaped_frame_decoder_unit_macros.svh"

module escaped_frame_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire  [7:0]                  rx_byte,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [2:0]                  kind,
  output logic [7:0]                  payload_byte,
  output logic [efd_pkg::COUNT_W-1:0] frame_count,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire  [efd_pkg::COUNT_W-1:0] cfg_data
);
  import efd_pkg::*;

  logic [COUNT_W-1:0] max_length;
  logic               push;
  efd_op_t            push_op;
  logic               pop;
  efd_op_t            pop_op;
  efd_qstat_t         qstat;

  // configuration register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length <= cfg_data;
    end
  end

  // byte classifier
  efd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .push     (push),
    .push_op  (push_op),
    .qstat    (qstat)
  );

  // op queue between classifier and frame engine
  efd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .pop_op  (pop_op),
    .qstat   (qstat)
  );

  // frame engine and output register
  efd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .pop_op       (pop_op),
    .pop          (pop),
    .max_length   (max_length),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .payload_byte (payload_byte),
    .frame_count  (frame_count)
  );

  // checks
  `EFD_ASSERT_IMP(a_payload_zero, out_valid && kind != KIND_PAYLOAD, payload_byte == 8'h00, "payload byte set on a non-payload beat")
  `EFD_ASSERT_IMP(a_count_zero, out_valid && kind != KIND_GOOD && kind != KIND_BAD, frame_count == '0, "frame count set on a non-frame-end beat")
  `EFD_ASSERT_IMP(a_count_range, out_valid && (kind == KIND_GOOD || kind == KIND_BAD), frame_count != '0, "zero frame count at frame end")
  `EFD_ASSERT_NXT(a_no_push_full, qstat.full && !pop, !push || qstat.full, "queue full yet accepting")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import efd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct packed {
    logic [2:0]         kind;
    logic [7:0]         data;
    logic [COUNT_W-1:0] count;
  } result_beat_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [7:0]         rx_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         kind;
  logic [7:0]         payload_byte;
  logic [COUNT_W-1:0] frame_count;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  escaped_frame_decoder_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .payload_byte(payload_byte),
    .frame_count (frame_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // raw bytes waiting to go out and decoded beats waiting to come back
  logic [7:0]   raw_byte_q[$];
  result_beat_t expected_beats[$];

  // decoder shadow state
  logic               esc_armed;
  logic [7:0]         hold_byte;
  logic               hold_ok;
  logic [COUNT_W-1:0] stored_cnt;
  logic [7:0]         frame_sum;
  logic [COUNT_W-1:0] len_limit;

  int n_queued = 0;
  int n_accepted = 0;
  int n_out = 0;
  int n_payload = 0;
  int n_restart = 0;
  int n_good = 0;
  int n_bad = 0;
  int n_lenerr = 0;
  int n_limit_writes = 0;
  int mismatches = 0;
  int cycle_cnt = 0;

  int burst_left = 0;
  int gap_left = 0;
  int stall_tick = 0;
  int stall_mode = 0;
  int stall_run = 0;

  task automatic push_expect(input logic [2:0] k, input logic [7:0] d,
                             input logic [COUNT_W-1:0] c);
    result_beat_t e;
    e.kind = k;
    e.data = d;
    e.count = c;
    expected_beats.push_back(e);
  endtask

  task automatic clear_frame();
    hold_ok = 1'b0;
    hold_byte = 8'h00;
    stored_cnt = '0;
    frame_sum = 8'h00;
  endtask

  // one byte into the frame, payload leaves one byte late
  task automatic store_into_frame(input logic [7:0] b);
    if (stored_cnt >= len_limit) begin
      clear_frame();
      push_expect(KIND_LENERR, 8'h00, '0);
    end else begin
      if (hold_ok) push_expect(KIND_PAYLOAD, hold_byte, '0);
      hold_byte = b;
      hold_ok = 1'b1;
      stored_cnt = stored_cnt + 1'b1;
      frame_sum = frame_sum + b;
    end
  endtask

  // unstuffing and frame check for one accepted raw byte
  task automatic decode_rx_byte(input logic [7:0] b);
    logic [7:0] body_sum;
    if (!esc_armed) begin
      if (b == ESC_BYTE) esc_armed = 1'b1;
      else store_into_frame(b);
    end else begin
      esc_armed = 1'b0;
      if (b == CODE_START) begin
        clear_frame();
        push_expect(KIND_RESTART, 8'h00, '0);
      end else if (b == CODE_LITERAL) begin
        store_into_frame(ESC_BYTE);
      end else if (b == CODE_END) begin
        if (stored_cnt == '0 || !hold_ok) begin
          clear_frame();
          push_expect(KIND_LENERR, 8'h00, '0);
        end else begin
          body_sum = frame_sum - hold_byte;
          push_expect((body_sum == hold_byte) ? KIND_GOOD : KIND_BAD, 8'h00, stored_cnt);
          clear_frame();
        end
      end else begin
        store_into_frame(b);
      end
    end
  endtask

  task automatic flag_mismatch(input string why, input result_beat_t want,
                               input result_beat_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s): expected kind %0d byte %02h count %0d, got kind %0d byte %02h count %0d",
               why, want.kind, want.data, want.count, got.kind, got.data, got.count);
  endtask

  // stimulus builders
  task automatic add_raw(input logic [7:0] b);
    raw_byte_q.push_back(b);
    n_queued++;
  endtask

  task automatic add_stuffed(input logic [7:0] b, input bit odd_escape);
    if (b == ESC_BYTE) begin
      add_raw(ESC_BYTE);
      add_raw(CODE_LITERAL);
    end else if (odd_escape && b != CODE_START && b != CODE_LITERAL && b != CODE_END) begin
      add_raw(ESC_BYTE);
      add_raw(b);
    end else begin
      add_raw(b);
    end
  endtask

  task automatic add_frame(input int n, input bit corrupt, input bit truncate);
    logic [7:0] ck;
    logic [7:0] b;
    ck = 8'h00;
    add_raw(ESC_BYTE);
    add_raw(CODE_START);
    for (int i = 0; i < n; i++) begin
      b = 8'($urandom_range(0, 255));
      ck = ck + b;
      add_stuffed(b, $urandom_range(0, 9) == 0);
    end
    if (!truncate) begin
      if (corrupt) ck = ck ^ (8'h01 << $urandom_range(0, 7));
      add_stuffed(ck, 1'b0);
      add_raw(ESC_BYTE);
      add_raw(CODE_END);
    end
  endtask

  task automatic add_noise(input int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 9);
      if (r < 3) add_raw(ESC_BYTE);
      else if (r < 5) add_raw(8'($urandom_range(1, 3)));
      else add_raw(8'($urandom_range(0, 255)));
    end
  endtask

  // mostly well-formed frames sized against the limit, plus broken ones
  task automatic add_random_traffic(input int limit, input int n_items);
    int start;
    int r;
    int n_max;
    start = n_queued;
    n_max = (limit == 0) ? 0 : ((limit - 1 > 12) ? 12 : limit - 1);
    while (n_queued - start < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        add_frame($urandom_range(0, n_max), $urandom_range(0, 4) == 0, 1'b0);
      end else if (r < 80) begin
        if (limit <= 40) add_frame($urandom_range(limit, limit + 3), 1'b0, 1'b0);
        else add_frame($urandom_range(0, n_max), 1'b0, 1'b0);
      end else if (r < 88) begin
        add_frame($urandom_range(0, 6), 1'b0, 1'b1);
      end else if (r < 92) begin
        add_raw(ESC_BYTE);
        add_raw(CODE_START);
        add_raw(ESC_BYTE);
        add_raw(CODE_END);
      end else begin
        add_noise($urandom_range(1, 6));
      end
    end
  endtask

  // wait until every byte is in and every beat is back, then let the queue drain
  task automatic wait_idle();
    while (n_accepted != n_queued || expected_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [COUNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    len_limit = v;
    n_limit_writes++;
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin : drive_proc
    logic       next_valid;
    logic [7:0] next_byte;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_byte = rx_byte;
      if (in_valid && in_ready) begin
        decode_rx_byte(rx_byte);
        n_accepted++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (raw_byte_q.size() > 0) begin
          next_byte = raw_byte_q.pop_front();
          next_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 16);
          end
        end
      end
      in_valid <= next_valid;
      rx_byte <= next_byte;
    end
  end

  // receiver: check each beat, then stall on a pattern that is re-picked at random
  always @(posedge clk) begin : monitor_proc
    result_beat_t got;
    result_beat_t want;
    logic         rdy;
    if (!rst && out_valid && out_ready) begin
      got.kind = kind;
      got.data = payload_byte;
      got.count = frame_count;
      n_out++;
      case (kind)
        KIND_PAYLOAD: n_payload++;
        KIND_RESTART: n_restart++;
        KIND_GOOD:    n_good++;
        KIND_BAD:     n_bad++;
        default:      n_lenerr++;
      endcase
      if (expected_beats.size() == 0) begin
        flag_mismatch("no beat expected", '0, got);
      end else begin
        want = expected_beats.pop_front();
        if (got.kind !== want.kind || got.data !== want.data || got.count !== want.count)
          flag_mismatch("field", want, got);
      end
    end
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: rdy = 1'b1;
      1: rdy = ($urandom_range(0, 9) < 7);
      2: rdy = (stall_tick % 3 == 0);
      default: begin
        if (stall_run > 0) begin
          stall_run--;
          rdy = 1'b0;
        end else begin
          rdy = 1'b1;
          if ($urandom_range(0, 7) == 0) stall_run = $urandom_range(1, 12);
        end
      end
    endcase
    out_ready <= rst ? 1'b0 : rdy;
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("[escaped_frame_decoder_unit] ERROR");
      $finish;
    end
  end

  // phases: directed bytes at the reset limit, then random traffic per limit
  initial begin
    int phase_limit[8];
    int phase_items[8];
    esc_armed = 1'b0;
    len_limit = MAX_LENGTH_RESET;
    clear_frame();
    phase_limit = '{1, 4096, 0, 8191, 7, 2, 3, 1};
    phase_limit[5] = $urandom_range(2, 40);
    phase_limit[7] = $urandom_range(1, 300);
    phase_items = '{100, 130, 80, 120, 150, 150, 100, 120};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // bytes before any start marker, then a bad checksum
    add_raw(8'h00);
    add_raw(8'hFF);
    add_raw(ESC_BYTE);
    add_raw(CODE_END);
    // end marker with nothing stored
    add_raw(ESC_BYTE);
    add_raw(CODE_END);
    // restart, then an empty frame
    add_raw(ESC_BYTE);
    add_raw(CODE_START);
    add_raw(ESC_BYTE);
    add_raw(CODE_END);
    // literal escape, other escaped byte, escape after escape, good checksum
    add_raw(ESC_BYTE);
    add_raw(CODE_START);
    add_raw(8'h12);
    add_raw(ESC_BYTE);
    add_raw(CODE_LITERAL);
    add_raw(ESC_BYTE);
    add_raw(8'h00);
    add_raw(ESC_BYTE);
    add_raw(ESC_BYTE);
    add_raw(8'hFF);
    add_raw(8'h12 + ESC_BYTE + 8'h00 + ESC_BYTE + 8'hFF);
    add_raw(ESC_BYTE);
    add_raw(CODE_END);
    // restart drops a held byte
    add_raw(8'h40);
    add_raw(ESC_BYTE);
    add_raw(CODE_START);
    wait_idle();

    foreach (phase_limit[p]) begin
      write_limit(COUNT_W'(phase_limit[p]));
      add_random_traffic(phase_limit[p], phase_items[p]);
      wait_idle();
    end

    if (expected_beats.size() != 0) begin
      mismatches += expected_beats.size();
      $display("%0d expected beats never arrived", expected_beats.size());
    end
    $display("sent %0d raw bytes over %0d limit settings, got %0d beats (%0d payload, %0d restart)",
             n_accepted, n_limit_writes + 1, n_out, n_payload, n_restart);
    $display("frames: %0d good, %0d bad checksum, %0d length errors; %0d mismatches",
             n_good, n_bad, n_lenerr, mismatches);
    if (mismatches == 0) begin
      $display("[escaped_frame_decoder_unit] OK");
    end else begin
      $display("[escaped_frame_decoder_unit] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/efd_pkg.sv
sv/efd_front.sv
sv/efd_queue.sv
sv/efd_back.sv
sv/escaped_frame_decoder_unit.sv
tb/tb_top.sv
